FILE: src/brace_fold_region_finder_unit_assert.svh
// Assertion macros for the checker of the brace fold region finder.
`ifndef BRACE_FOLD_REGION_FINDER_UNIT_ASSERT_SVH
`define BRACE_FOLD_REGION_FINDER_UNIT_ASSERT_SVH

// General property under the async active-low reset.
`define BFR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal is stable in the cycle after the condition.
`define BFR_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

FILE: src/bfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_pkg
// Types and constants of the brace fold region finder.
// ----------------------------------------------------------------------------
package bfr_pkg;

	localparam int INDENT_W    = 12;
	localparam int OUT_LINE_W  = 16;
	localparam int MIN_W       = 16;
	localparam int TAB_W       = 5;
	localparam int CHAR_W      = 8;
	localparam int CFG_ADDR_W  = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int OUT_TDATA_W = 48;

	localparam logic [INDENT_W-1:0] INDENT_MAX = 12'hFFF;
	localparam logic [TAB_W-1:0]    TAB_RESET  = 5'd4;

	localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h7B;
	localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h7D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;

	localparam logic REQ_CHAR = 1'b0;
	localparam logic REQ_EOL  = 1'b1;

	localparam logic [CFG_ADDR_W-1:0] REG_MIN_FOLD  = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_TAB_WIDTH = 1'd1;

	typedef struct packed {
		logic push;
		logic pop;
	} stack_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} stack_stat_t;

endpackage

FILE: src/brace_fold_region_finder_unit.sv
`timescale 1ns / 1ps
// A region enters the output buffer as its closing brace is accepted; m_tvalid is registered.
// Throughput: one request per cycle while s_tready is high; the stack is a chain of STACK_DEPTH cells
// that all shift together on every push or pop that the stack takes.
// A two-entry output buffer keeps s_tready high unless both entries are held.
// Reset (arst_n low): counters, stack count, overflow flag and buffers clear;
// registers return to min_fold_lines = 0 and tab_width = 4.
// ----------------------------------------------------------------------------
// brace_fold_region_finder_unit
// Finds brace-delimited fold regions in a text stream.
// ----------------------------------------------------------------------------
module brace_fold_region_finder_unit #(
	parameter int STACK_DEPTH = 64,
	parameter int LINE_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [bfr_pkg::CHAR_W-1:0]          s_tdata,  // char_code
	input  logic [0:0]                          s_tuser,  // req_type
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// open line[15:0], close line[31:16], open indent[43:32], overflow[44], zero pad
	output logic [bfr_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  logic [bfr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [bfr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int ENTRY_W = LINE_BITS + bfr_pkg::INDENT_W;
	localparam int CMP_W   = (LINE_BITS > bfr_pkg::MIN_W) ? LINE_BITS : bfr_pkg::MIN_W;

	logic [bfr_pkg::MIN_W-1:0]    min_fold_q;
	logic [bfr_pkg::TAB_W-1:0]    tab_width_q;
	logic [LINE_BITS-1:0]         line_q;
	logic [bfr_pkg::INDENT_W-1:0] indent_q;
	logic                         lead_q;
	logic                         overflow_q;

	logic                         accept;
	logic                         is_eol;
	logic                         is_space;
	logic                         is_tab;
	logic                         in_lead_ws;
	logic                         brace_ok;
	logic                         open_hit;
	logic                         close_hit;
	logic [bfr_pkg::INDENT_W:0]   indent_sum;
	logic [bfr_pkg::INDENT_W-1:0] indent_add;

	bfr_pkg::stack_ctl_t          stk_ctl;
	bfr_pkg::stack_stat_t         stk_stat;
	logic [ENTRY_W-1:0]           top_entry;
	logic [LINE_BITS-1:0]         top_line;
	logic [bfr_pkg::INDENT_W-1:0] top_indent;

	logic [CMP_W-1:0]             start_ext;
	logic [CMP_W-1:0]             end_ext;
	logic [CMP_W-1:0]             span;
	logic                         res_valid;
	logic [bfr_pkg::OUT_TDATA_W-1:0] res_data;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_fold_q  <= '0;
			tab_width_q <= bfr_pkg::TAB_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				bfr_pkg::REG_MIN_FOLD:  min_fold_q  <= cfg_wdata;
				bfr_pkg::REG_TAB_WIDTH: tab_width_q <= cfg_wdata[bfr_pkg::TAB_W-1:0];
				default: ;
			endcase
		end
	end

	// request decode
	always_comb begin
		accept     = s_tvalid && s_tready;
		is_eol     = (s_tuser[0] == bfr_pkg::REQ_EOL);
		is_space   = (s_tdata == bfr_pkg::CH_SPACE);
		is_tab     = (s_tdata == bfr_pkg::CH_TAB);
		in_lead_ws = lead_q && (is_space || is_tab);
		brace_ok   = accept && !is_eol && !in_lead_ws;
		open_hit   = brace_ok && (s_tdata == bfr_pkg::CH_OPEN);
		close_hit  = brace_ok && (s_tdata == bfr_pkg::CH_CLOSE);

		indent_add = is_tab ? bfr_pkg::INDENT_W'(tab_width_q) : bfr_pkg::INDENT_W'(1);
		indent_sum = {1'b0, indent_q} + {1'b0, indent_add};

		stk_ctl.push = open_hit;
		stk_ctl.pop  = close_hit;
	end

	// line, indent and overflow tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q     <= '0;
			indent_q   <= '0;
			lead_q     <= 1'b1;
			overflow_q <= 1'b0;
		end else if (accept) begin
			if (is_eol) begin
				if (!(&line_q)) begin
					line_q <= line_q + 1'b1;
				end
				indent_q <= '0;
				lead_q   <= 1'b1;
			end else if (in_lead_ws) begin
				indent_q <= indent_sum[bfr_pkg::INDENT_W] ? bfr_pkg::INDENT_MAX
					: indent_sum[bfr_pkg::INDENT_W-1:0];
			end else begin
				lead_q <= 1'b0;
				if (open_hit && stk_stat.full) begin
					overflow_q <= 1'b1;
				end
			end
		end
	end

	bfr_stack #(
		.DEPTH  (STACK_DEPTH),
		.ENTRY_W(ENTRY_W)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (stk_ctl),
		.push_entry({line_q, indent_q}),
		.top_entry (top_entry),
		.stat      (stk_stat)
	);

	// region check on the popped entry
	always_comb begin
		top_line   = top_entry[ENTRY_W-1:bfr_pkg::INDENT_W];
		top_indent = top_entry[bfr_pkg::INDENT_W-1:0];
		start_ext  = CMP_W'(top_line);
		end_ext    = CMP_W'(line_q);
		span       = end_ext - start_ext;
		res_valid  = close_hit && !stk_stat.empty && (span >= CMP_W'(min_fold_q));
		res_data   = {3'b000, overflow_q, top_indent,
			end_ext[bfr_pkg::OUT_LINE_W-1:0], start_ext[bfr_pkg::OUT_LINE_W-1:0]};
	end

	bfr_out_buf #(
		.W(bfr_pkg::OUT_TDATA_W)
	) u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_data  (res_data),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata)
	);

endmodule

FILE: src/bfr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_cell
// One stack entry; shifts down on push and up on pop.
// ----------------------------------------------------------------------------
module bfr_cell #(
	parameter int W = 28
) (
	input  logic               clk,
	input  bfr_pkg::stack_ctl_t ctl,
	input  logic [W-1:0]       up_d,
	input  logic [W-1:0]       down_d,
	output logic [W-1:0]       entry_q
);

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= up_d;
		end else if (ctl.pop) begin
			entry_q <= down_d;
		end
	end

endmodule

FILE: src/bfr_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_stack
// Open-brace stack as a chain of cells with the top in cell 0.
// ----------------------------------------------------------------------------
module bfr_stack #(
	parameter int DEPTH   = 64,
	parameter int ENTRY_W = 28
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bfr_pkg::stack_ctl_t  ctl,
	input  logic [ENTRY_W-1:0]   push_entry,
	output logic [ENTRY_W-1:0]   top_entry,
	output bfr_pkg::stack_stat_t stat
);

	localparam int PTR_W = $clog2(DEPTH + 1);

	logic [PTR_W-1:0]   count_q;
	logic [ENTRY_W-1:0] cell_q [DEPTH];
	bfr_pkg::stack_ctl_t cell_ctl;

	always_comb begin
		stat.empty    = (count_q == '0);
		stat.full     = (count_q == PTR_W'(DEPTH));
		// drop a push on a full stack and a pop on an empty one
		cell_ctl.push = ctl.push && !stat.full;
		cell_ctl.pop  = ctl.pop && !stat.empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cell_ctl.push) begin
			count_q <= count_q + 1'b1;
		end else if (cell_ctl.pop) begin
			count_q <= count_q - 1'b1;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ENTRY_W-1:0] up_d;
		logic [ENTRY_W-1:0] down_d;

		if (i == 0) begin : g_head
			assign up_d = push_entry;
		end else begin : g_body
			assign up_d = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign down_d = cell_q[i];
		end else begin : g_inner
			assign down_d = cell_q[i+1];
		end

		bfr_cell #(
			.W(ENTRY_W)
		) u_cell (
			.clk    (clk),
			.ctl    (cell_ctl),
			.up_d   (up_d),
			.down_d (down_d),
			.entry_q(cell_q[i])
		);
	end

	assign top_entry = cell_q[0];

endmodule

FILE: src/bfr_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_out_buf
// Output register with a skid entry behind it.
// ----------------------------------------------------------------------------
module bfr_out_buf #(
	parameter int W = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [W-1:0] in_data,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic         out_valid_q;
	logic [W-1:0] out_data_q;
	logic         skid_valid_q;
	logic [W-1:0] skid_data_q;
	logic         take;

	assign take      = out_valid_q && out_ready;
	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (in_valid) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
			end
		end else if (in_valid) begin
			if (!out_valid_q || take) begin
				out_data_q <= in_data;
			end else begin
				skid_data_q <= in_data;
			end
		end
	end

endmodule

FILE: src/bfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_checker
// Port-level checks of the brace fold region finder.
// ----------------------------------------------------------------------------
`include "brace_fold_region_finder_unit_assert.svh"

module bfr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [bfr_pkg::CHAR_W-1:0]      s_tdata,
	input logic [0:0]                      s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [bfr_pkg::OUT_TDATA_W-1:0] m_tdata
);

	`BFR_ASSERT_HOLD(a_valid_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")
	`BFR_ASSERT_HOLD(a_data_hold, clk, arst_n, m_tvalid && !m_tready, m_tdata, "m_tdata changed while stalled")
	`BFR_ASSERT(a_stall_needs_out, clk, arst_n, !s_tready |-> m_tvalid, "input stalled with empty output")
	`BFR_ASSERT(a_rise_from_close, clk, arst_n, $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser[0] == bfr_pkg::REQ_CHAR && s_tdata == bfr_pkg::CH_CLOSE), "region without closing brace")

endmodule

bind brace_fold_region_finder_unit bfr_checker u_bfr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

FILE: tb/sv/brace_fold_region_finder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brace_fold_region_finder_unit_test
// Drives text streams of lines, indents and braces into the fold region finder.
// A line-level predictor tracks line count, indent and the brace stack, then
// checks every region the block emits. The run covers empty and full stack,
// short regions, indent saturation, and several register settings.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module brace_fold_region_finder_unit_test;

	localparam int STACK_DEPTH = 64;

	// Predicts the fold regions of the text seen so far and holds the ones not yet received.
	class fold_tracker;
		typedef struct {
			logic [15:0] first_line;
			logic [15:0] last_line;
			logic [11:0] indent;
			logic        ovf;
		} region_t;

		logic [15:0] min_span;
		logic [4:0]  tab_cols;
		logic [15:0] line_no;
		logic [11:0] indent;
		logic        leading;
		logic [15:0] open_line [STACK_DEPTH];
		logic [11:0] open_indent [STACK_DEPTH];
		int          depth;
		logic        dropped;
		region_t     pending [$];
		int          errors;

		function new();
			min_span = '0;
			tab_cols = bfr_pkg::TAB_RESET;
			line_no  = '0;
			indent   = '0;
			leading  = 1'b1;
			depth    = 0;
			dropped  = 1'b0;
			errors   = 0;
		endfunction

		function void write_reg(logic [bfr_pkg::CFG_ADDR_W-1:0] idx,
			logic [bfr_pkg::CFG_DATA_W-1:0] value);
			if (idx == bfr_pkg::REG_MIN_FOLD)
				min_span = value;
			else if (idx == bfr_pkg::REG_TAB_WIDTH)
				tab_cols = value[bfr_pkg::TAB_W-1:0];
		endfunction

		function void grow_indent(logic [12:0] amount);
			logic [12:0] sum;
			sum = {1'b0, indent} + amount;
			indent = (sum > {1'b0, bfr_pkg::INDENT_MAX}) ? bfr_pkg::INDENT_MAX : sum[11:0];
		endfunction

		function void take_request(logic kind, logic [7:0] ch);
			region_t r;
			if (kind == bfr_pkg::REQ_EOL) begin
				if (line_no != 16'hFFFF)
					line_no++;
				indent  = '0;
				leading = 1'b1;
				return;
			end
			if (leading) begin
				if (ch == bfr_pkg::CH_SPACE) begin
					grow_indent(13'd1);
					return;
				end
				if (ch == bfr_pkg::CH_TAB) begin
					grow_indent({8'd0, tab_cols});
					return;
				end
				leading = 1'b0;
			end
			if (ch == bfr_pkg::CH_OPEN) begin
				if (depth < STACK_DEPTH) begin
					open_line[depth]   = line_no;
					open_indent[depth] = indent;
					depth++;
				end else begin
					dropped = 1'b1;
				end
			end else if (ch == bfr_pkg::CH_CLOSE && depth > 0) begin
				depth--;
				if (line_no - open_line[depth] >= min_span) begin
					r.first_line = open_line[depth];
					r.last_line  = line_no;
					r.indent     = open_indent[depth];
					r.ovf        = dropped;
					pending.insert(pending.size(), r);
				end
			end
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void compare_region(logic [bfr_pkg::OUT_TDATA_W-1:0] data);
			region_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: region with none expected, expected nothing, actual %h",
					$time, data);
				return;
			end
			want = pending.pop_front();
			check_field("region start", want.first_line, data[15:0]);
			check_field("region end", want.last_line, data[31:16]);
			check_field("region indent", {4'd0, want.indent}, {4'd0, data[43:32]});
			check_field("overflow flag", {15'd0, want.ovf}, {15'd0, data[44]});
		endfunction
	endclass

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [bfr_pkg::CHAR_W-1:0]      s_tdata   = '0;
	logic [0:0]                      s_tuser   = '0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [bfr_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            cfg_we    = 1'b0;
	logic [bfr_pkg::CFG_ADDR_W-1:0]  cfg_addr  = '0;
	logic [bfr_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

	fold_tracker tracker = new();
	bit          idle_on = 1'b1;
	bit          stall_start = 1'b0;
	int          stall_left = 0;
	int          items_sent = 0;

	brace_fold_region_finder_unit #(
		.STACK_DEPTH(STACK_DEPTH),
		.LINE_BITS  (16)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side: random back-pressure plus a long hold-off when a test starts one.
	always @(posedge clk) begin
		if (stall_start) begin
			stall_start = 1'b0;
			stall_left  = 150;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on) begin
			m_tready <= ($urandom_range(99) >= 12);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.compare_region(m_tdata);
	end

	task automatic send_req(logic kind, logic [7:0] ch);
		if (idle_on && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= ch;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.take_request(kind, ch);
		items_sent++;
	endtask

	// Hold the input until every predicted region has come out, then let the pipe settle.
	task automatic await_quiet();
		s_tvalid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [bfr_pkg::CFG_ADDR_W-1:0] idx,
		logic [bfr_pkg::CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.write_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic send_char(logic [7:0] ch);
		send_req(bfr_pkg::REQ_CHAR, ch);
	endtask

	task automatic send_eol();
		send_req(bfr_pkg::REQ_EOL, 8'($urandom_range(255)));
	endtask

	// Mostly well-formed lines: indent, a body with braces, one or more line ends.
	task automatic send_random_lines(int budget);
		int          stop_at;
		int          r;
		logic [7:0]  c;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 6) begin
				send_req(1'($urandom_range(1)), 8'($urandom_range(255)));
				continue;
			end
			repeat ($urandom_range(5))
				send_char($urandom_range(1) ? bfr_pkg::CH_SPACE : bfr_pkg::CH_TAB);
			repeat ($urandom_range(6)) begin
				r = $urandom_range(99);
				if (r < 20)
					c = (tracker.depth < 40) ? bfr_pkg::CH_OPEN : 8'h61;
				else if (r < 40)
					c = bfr_pkg::CH_CLOSE;
				else if (r < 50)
					c = 8'($urandom_range(255));
				else if (r < 56)
					c = bfr_pkg::CH_SPACE;
				else if (r < 60)
					c = bfr_pkg::CH_TAB;
				else
					c = 8'h61 + 8'($urandom_range(25));
				send_char(c);
			end
			repeat ($urandom_range(3, 1)) send_eol();
		end
	endtask

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// close on an empty stack, then an indented open matched one line down
		send_char(bfr_pkg::CH_CLOSE);
		send_eol();
		send_char(bfr_pkg::CH_SPACE);
		send_char(bfr_pkg::CH_TAB);
		send_char(bfr_pkg::CH_OPEN);
		send_char(8'hFF);
		send_eol();
		send_char(8'h00);
		send_char(bfr_pkg::CH_CLOSE);

		// zero tab width adds nothing
		await_quiet();
		write_reg(bfr_pkg::REG_TAB_WIDTH, 16'd0);
		send_char(bfr_pkg::CH_TAB);
		send_char(bfr_pkg::CH_TAB);
		send_char(bfr_pkg::CH_SPACE);
		send_char(bfr_pkg::CH_OPEN);
		send_char(bfr_pkg::CH_CLOSE);
		send_eol();

		// tab width above range keeps only its low five bits
		await_quiet();
		write_reg(bfr_pkg::REG_TAB_WIDTH, 16'hFFFF);
		send_char(bfr_pkg::CH_TAB);
		send_char(bfr_pkg::CH_OPEN);
		send_eol();
		send_char(bfr_pkg::CH_CLOSE);
		send_eol();

		// saturate the indent
		repeat (140) send_char(bfr_pkg::CH_TAB);
		send_char(bfr_pkg::CH_OPEN);
		send_char(bfr_pkg::CH_CLOSE);
		send_eol();

		// region shorter than the minimum span is dropped
		await_quiet();
		write_reg(bfr_pkg::REG_MIN_FOLD, 16'd2);
		send_char(bfr_pkg::CH_OPEN);
		send_eol();
		send_char(bfr_pkg::CH_CLOSE);
		send_char(bfr_pkg::CH_OPEN);
		send_eol();
		send_eol();
		send_char(bfr_pkg::CH_CLOSE);
		send_eol();

		await_quiet();
		write_reg(bfr_pkg::REG_MIN_FOLD, 16'd0);
		write_reg(bfr_pkg::REG_TAB_WIDTH, 16'd4);
		send_random_lines(200);

		// no idling on either side for a while
		await_quiet();
		write_reg(bfr_pkg::REG_MIN_FOLD, 16'd3);
		write_reg(bfr_pkg::REG_TAB_WIDTH, {11'($urandom_range(2047)), 5'd1});
		idle_on = 1'b0;
		send_random_lines(150);
		idle_on = 1'b1;

		// receiver holds off while regions keep coming
		await_quiet();
		write_reg(bfr_pkg::REG_MIN_FOLD, 16'd0);
		stall_start = 1'b1;
		repeat (60) begin
			send_char(bfr_pkg::CH_OPEN);
			send_char(bfr_pkg::CH_CLOSE);
		end
		send_eol();

		await_quiet();
		write_reg(bfr_pkg::REG_MIN_FOLD, 16'hFFFF);
		write_reg(bfr_pkg::REG_TAB_WIDTH, 16'd16);
		send_random_lines(100);

		await_quiet();
		write_reg(bfr_pkg::REG_MIN_FOLD, 16'd1);
		write_reg(bfr_pkg::REG_TAB_WIDTH, 16'd8);
		send_random_lines(150);

		// overfill the stack; the sticky flag rides on every later region
		await_quiet();
		write_reg(bfr_pkg::REG_MIN_FOLD, 16'd0);
		send_eol();
		repeat (STACK_DEPTH + 6) send_char(bfr_pkg::CH_OPEN);
		repeat (10) send_char(bfr_pkg::CH_CLOSE);
		send_eol();
		send_random_lines(60);

		s_tvalid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: brace_fold_region_finder_unit.f
+incdir+src
src/bfr_pkg.sv
src/bfr_cell.sv
src/bfr_stack.sv
src/bfr_out_buf.sv
src/brace_fold_region_finder_unit.sv
src/bfr_checker.sv
tb/sv/brace_fold_region_finder_unit_test.sv
